FILE: rtl/core/dsb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsb_pkg
// Shared constants, field layout, lane control type and saturation helper
// for the delay-and-sum beamformer.
// ----------------------------------------------------------------------------
package dsb_pkg;

  localparam int MICS        = 4;
  localparam int LINE_DEPTH  = 64;
  localparam int TAPS        = 11;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int COEF_FRAC   = 14;

  // fixed widths of the item fields
  localparam int MODE_FW = 2;
  localparam int MIC_FW  = 2;
  localparam int TAP_FW  = 4;
  localparam int DLY_FW  = 6;

  localparam int DLY_W  = $clog2(LINE_DEPTH);
  localparam int TAP_W  = $clog2(TAPS);
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int GRP    = 4;
  localparam int NGRP   = (TAPS + GRP - 1) / GRP;
  localparam int ACC_W  = PROD_W + $clog2(TAPS) + 1;
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MICS) + 1;
  // averaging is an arithmetic shift, so the channel count is a power of two
  localparam int MICS_LOG2 = $clog2(MICS);

  // input tdata layout, lowest bit first
  localparam int OFS_MIC    = MICS * SAMPLE_BITS;
  localparam int OFS_TAP    = OFS_MIC + MIC_FW;
  localparam int OFS_COEF   = OFS_TAP + TAP_FW;
  localparam int OFS_DLY    = OFS_COEF + COEF_BITS;
  localparam int OFS_EN     = OFS_DLY + DLY_FW;
  localparam int IN_BITS    = OFS_EN + 1;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  typedef enum logic [MODE_FW-1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_COEF   = 2'd1,
    MODE_CHAN   = 2'd2
  } mode_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic                        smp_acc;
    logic                        coef_we;
    logic                        chan_we;
    logic [TAP_W-1:0]            tap;
    logic signed [COEF_BITS-1:0] coef;
    logic [DLY_W-1:0]            delay;
    logic                        fir_en;
    logic [DLY_W-1:0]            wp;
    logic                        ld2;
    logic                        ld3;
    logic                        ld4;
  } lane_ctrl_t;

  function automatic sample_t sat_sample(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_BITS-1:0];
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

FILE: rtl/core/dsb_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsb_lane
// One microphone channel: circular delay line, channel settings, coefficient
// and history registers, parallel tap products and a registered adder tree.
// ----------------------------------------------------------------------------
module dsb_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dsb_pkg::lane_ctrl_t ctrl_i,
  input  dsb_pkg::sample_t    sample_i,
  output dsb_pkg::sample_t    lane_o
);

  logic [dsb_pkg::DLY_W-1:0]            delay_q;
  logic                                 fir_on_q;
  logic signed [dsb_pkg::COEF_BITS-1:0] coef_q [dsb_pkg::TAPS];
  dsb_pkg::sample_t                     hist_q [dsb_pkg::TAPS-1];

  dsb_pkg::sample_t                     mem_q [dsb_pkg::LINE_DEPTH];
  logic [dsb_pkg::LINE_DEPTH-1:0]       vld_q;
  logic [dsb_pkg::DLY_W-1:0]            rd_addr;

  dsb_pkg::sample_t                     rdata_q;
  dsb_pkg::sample_t                     smp_s1_q;
  logic                                 rvld_q;
  logic                                 byp_s1_q;
  logic                                 fir_s1_q;
  dsb_pkg::sample_t                     x_s1;
  dsb_pkg::sample_t                     tapv [dsb_pkg::TAPS];

  logic signed [dsb_pkg::PROD_W-1:0]    prod_q [dsb_pkg::TAPS];
  dsb_pkg::sample_t                     x_s2_q;
  logic                                 fir_s2_q;

  logic signed [dsb_pkg::ACC_W-1:0]     grp_sum [dsb_pkg::NGRP];
  logic signed [dsb_pkg::ACC_W-1:0]     part_q [dsb_pkg::NGRP];
  dsb_pkg::sample_t                     x_s3_q;
  logic                                 fir_s3_q;

  logic signed [dsb_pkg::ACC_W-1:0]     acc_sum;
  logic signed [dsb_pkg::ACC_W-1:0]     acc_rnd;
  logic signed [dsb_pkg::ACC_W-1:0]     acc_shr;
  dsb_pkg::sample_t                     val_q;

  // channel settings and coefficients
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q  <= '0;
      fir_on_q <= 1'b0;
      for (int k = 0; k < dsb_pkg::TAPS; k++) begin
        coef_q[k] <= '0;
      end
    end else begin
      if (ctrl_i.chan_we) begin
        delay_q  <= ctrl_i.delay;
        fir_on_q <= ctrl_i.fir_en;
      end
      for (int k = 0; k < dsb_pkg::TAPS; k++) begin
        if (ctrl_i.coef_we && ctrl_i.tap == dsb_pkg::TAP_W'(k)) begin
          coef_q[k] <= ctrl_i.coef;
        end
      end
    end
  end

  // read address wraps around the circular line
  always_comb begin
    if (ctrl_i.wp >= delay_q) begin
      rd_addr = ctrl_i.wp - delay_q;
    end else begin
      rd_addr = dsb_pkg::DLY_W'({1'b0, ctrl_i.wp} +
                (dsb_pkg::DLY_W+1)'(dsb_pkg::LINE_DEPTH) - {1'b0, delay_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.smp_acc) begin
      mem_q[ctrl_i.wp] <= sample_i;
      rdata_q          <= mem_q[rd_addr];
      smp_s1_q         <= sample_i;
      byp_s1_q         <= (delay_q == '0);
      fir_s1_q         <= fir_on_q;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else if (ctrl_i.smp_acc) begin
      vld_q[ctrl_i.wp] <= 1'b1;
      rvld_q           <= vld_q[rd_addr];
    end
  end

  // zero delay takes the sample of the current item
  always_comb begin
    if (byp_s1_q) begin
      x_s1 = smp_s1_q;
    end else if (rvld_q) begin
      x_s1 = rdata_q;
    end else begin
      x_s1 = '0;
    end
    tapv[0] = x_s1;
    for (int k = 1; k < dsb_pkg::TAPS; k++) begin
      tapv[k] = hist_q[k-1];
    end
  end

  // history shifts on every sample item, filtered or not
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < dsb_pkg::TAPS-1; k++) begin
        hist_q[k] <= '0;
      end
    end else if (ctrl_i.ld2) begin
      hist_q[0] <= x_s1;
      for (int k = 1; k < dsb_pkg::TAPS-1; k++) begin
        hist_q[k] <= hist_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld2) begin
      for (int k = 0; k < dsb_pkg::TAPS; k++) begin
        prod_q[k] <= dsb_pkg::PROD_W'(coef_q[k] * tapv[k]);
      end
      x_s2_q   <= x_s1;
      fir_s2_q <= fir_s1_q;
    end
  end

  always_comb begin
    for (int g = 0; g < dsb_pkg::NGRP; g++) begin
      grp_sum[g] = '0;
      for (int i = 0; i < dsb_pkg::GRP; i++) begin
        if (g * dsb_pkg::GRP + i < dsb_pkg::TAPS) begin
          grp_sum[g] = grp_sum[g] + dsb_pkg::ACC_W'(prod_q[g * dsb_pkg::GRP + i]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld3) begin
      for (int g = 0; g < dsb_pkg::NGRP; g++) begin
        part_q[g] <= grp_sum[g];
      end
      x_s3_q   <= x_s2_q;
      fir_s3_q <= fir_s2_q;
    end
  end

  // round half up to q1.15, floor shift
  always_comb begin
    acc_sum = '0;
    for (int g = 0; g < dsb_pkg::NGRP; g++) begin
      acc_sum = acc_sum + part_q[g];
    end
    acc_rnd = acc_sum + (dsb_pkg::ACC_W'(1) << (dsb_pkg::COEF_FRAC - 1));
    acc_shr = acc_rnd >>> dsb_pkg::COEF_FRAC;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld4) begin
      val_q <= fir_s3_q ? dsb_pkg::sat_sample(acc_shr) : x_s3_q;
    end
  end

  assign lane_o = val_q;

endmodule

FILE: rtl/core/dsb_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsb_merge
// Sums the lane values, averages with rounding and saturation, and holds the
// beam sample in the output register.
// ----------------------------------------------------------------------------
module dsb_merge (
  input  logic             clk_i,
  input  logic             ld_i,
  input  dsb_pkg::sample_t lane_i [dsb_pkg::MICS],
  output dsb_pkg::sample_t beam_o
);

  logic signed [dsb_pkg::SUM_W-1:0] sum;
  logic signed [dsb_pkg::SUM_W-1:0] rnd;
  logic signed [dsb_pkg::SUM_W-1:0] avg;
  dsb_pkg::sample_t                 beam_q;

  always_comb begin
    sum = '0;
    for (int m = 0; m < dsb_pkg::MICS; m++) begin
      sum = sum + dsb_pkg::SUM_W'(lane_i[m]);
    end
    rnd = sum + dsb_pkg::SUM_W'(dsb_pkg::MICS / 2);
    // floor division by the channel count
    avg = rnd >>> dsb_pkg::MICS_LOG2;
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      beam_q <= dsb_pkg::sat_sample(dsb_pkg::ACC_W'(avg));
    end
  end

  assign beam_o = beam_q;

endmodule

FILE: rtl/core/delay_and_sum_beamformer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delay_and_sum_beamformer_unit
// Delay-and-sum beamformer with per-channel integer delay and fractional FIR.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_axis group; tuser carries the item kind.
//   A sample item writes one sample per microphone into the delay lines and
//   yields one beam sample on the m_axis group. Coefficient and channel load
//   items update settings in the cycle they are taken and yield no item.
//   Each channel is a lane of its own; the lanes run in lockstep and a merge
//   stage averages their values into the output register.
//   Throughput: one item per cycle while the receiver does not stall, set by
//   the four-stage lane pipeline (delay line read, tap products, group sums,
//   final sum and rounding); the merge output register follows it.
//   Reset clears delays, enables, coefficients, FIR history and delay-line
//   valid bits at once, so no sweep is needed after reset.
//   When the receiver stalls, items keep flowing into empty pipeline stages;
//   s_axis_tready falls only once all five stages, output register included,
//   hold items.
// ----------------------------------------------------------------------------
module delay_and_sum_beamformer_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // sample_0, sample_1, sample_2, sample_3, mic_index, tap_index,
  // coef_value, delay_value, fir_enable, zero pad
  input  logic [dsb_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // mode
  input  logic [dsb_pkg::MODE_FW-1:0]      s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // beam_sample
  output logic [dsb_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);

  dsb_pkg::mode_e              mode;
  logic                        is_smp;
  logic                        is_coef;
  logic                        is_chan;
  logic                        mic_ok;
  logic                        tap_ok;
  logic [dsb_pkg::MIC_FW-1:0]  mic_f;
  logic [dsb_pkg::TAP_FW-1:0]  tap_f;
  logic [dsb_pkg::DLY_FW-1:0]  dly_f;
  logic [dsb_pkg::DLY_W-1:0]   d_sat;
  logic                        in_acc;
  logic                        smp_acc;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic v1_d, v2_d, v3_d, v4_d, v5_d;
  logic adv1, adv2, adv3, adv4, adv5;
  logic ld2, ld3, ld4, ld5;

  logic [dsb_pkg::DLY_W-1:0]   wp_q;
  logic [dsb_pkg::DLY_W-1:0]   wp_d;

  dsb_pkg::lane_ctrl_t         lane_ctrl [dsb_pkg::MICS];
  dsb_pkg::sample_t            lane_val [dsb_pkg::MICS];
  dsb_pkg::sample_t            beam;

  assign mode  = dsb_pkg::mode_e'(s_axis_tuser_i);
  assign mic_f = s_axis_tdata_i[dsb_pkg::OFS_MIC +: dsb_pkg::MIC_FW];
  assign tap_f = s_axis_tdata_i[dsb_pkg::OFS_TAP +: dsb_pkg::TAP_FW];
  assign dly_f = s_axis_tdata_i[dsb_pkg::OFS_DLY +: dsb_pkg::DLY_FW];

  always_comb begin
    is_smp  = 1'b0;
    is_coef = 1'b0;
    is_chan = 1'b0;
    unique case (mode)
      dsb_pkg::MODE_SAMPLE: is_smp  = 1'b1;
      dsb_pkg::MODE_COEF:   is_coef = 1'b1;
      dsb_pkg::MODE_CHAN:   is_chan = 1'b1;
      default: ;
    endcase
  end

  assign mic_ok = int'(mic_f) < dsb_pkg::MICS;
  assign tap_ok = int'(tap_f) < dsb_pkg::TAPS;
  assign d_sat  = (int'(dly_f) > dsb_pkg::LINE_DEPTH - 1) ?
                  dsb_pkg::DLY_W'(dsb_pkg::LINE_DEPTH - 1) : dsb_pkg::DLY_W'(dly_f);

  // stage handshake, output register last
  always_comb begin
    adv5 = !v5_q || m_axis_tready_i;
    ld5  = v4_q && adv5;
    adv4 = !v4_q || adv5;
    ld4  = v3_q && adv4;
    adv3 = !v3_q || adv4;
    ld3  = v2_q && adv3;
    adv2 = !v2_q || adv3;
    ld2  = v1_q && adv2;
    adv1 = !v1_q || adv2;
  end

  assign s_axis_tready_o = adv1;
  assign in_acc          = s_axis_tvalid_i && adv1;
  assign smp_acc         = in_acc && is_smp;

  always_comb begin
    v1_d = smp_acc || (v1_q && !ld2);
    v2_d = ld2 || (v2_q && !ld3);
    v3_d = ld3 || (v3_q && !ld4);
    v4_d = ld4 || (v4_q && !ld5);
    v5_d = ld5 || (v5_q && !m_axis_tready_i);
    wp_d = wp_q;
    if (smp_acc) begin
      wp_d = (wp_q == dsb_pkg::DLY_W'(dsb_pkg::LINE_DEPTH - 1)) ? '0
                                                                : wp_q + dsb_pkg::DLY_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      wp_q <= '0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
      v5_q <= v5_d;
      wp_q <= wp_d;
    end
  end

  always_comb begin
    for (int m = 0; m < dsb_pkg::MICS; m++) begin
      lane_ctrl[m].smp_acc = smp_acc;
      lane_ctrl[m].coef_we = in_acc && is_coef && mic_ok && tap_ok && (int'(mic_f) == m);
      lane_ctrl[m].chan_we = in_acc && is_chan && mic_ok && (int'(mic_f) == m);
      lane_ctrl[m].tap     = dsb_pkg::TAP_W'(tap_f);
      lane_ctrl[m].coef    = s_axis_tdata_i[dsb_pkg::OFS_COEF +: dsb_pkg::COEF_BITS];
      lane_ctrl[m].delay   = d_sat;
      lane_ctrl[m].fir_en  = s_axis_tdata_i[dsb_pkg::OFS_EN];
      lane_ctrl[m].wp      = wp_q;
      lane_ctrl[m].ld2     = ld2;
      lane_ctrl[m].ld3     = ld3;
      lane_ctrl[m].ld4     = ld4;
    end
  end

  for (genvar m = 0; m < dsb_pkg::MICS; m++) begin : g_lane
    dsb_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl[m]),
      .sample_i (s_axis_tdata_i[m*dsb_pkg::SAMPLE_BITS +: dsb_pkg::SAMPLE_BITS]),
      .lane_o   (lane_val[m])
    );
  end

  dsb_merge u_merge (
    .clk_i  (clk_i),
    .ld_i   (ld5),
    .lane_i (lane_val),
    .beam_o (beam)
  );

  assign m_axis_tvalid_o = v5_q;
  assign m_axis_tdata_o  = dsb_pkg::OUT_DATA_W'($unsigned(beam));

`ifndef SYNTHESIS
  // a full pipeline behind a stalled receiver takes no item
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && v4_q && v5_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("item taken while pipeline full and stalled");

  // a sample item always occupies the first stage next cycle
  a_smp_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_acc |=> v1_q)
    else $error("sample item lost at first stage");

  // load items never enter the lane pipeline
  a_load_no_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !is_smp && !ld2) |=> (v1_q == $past(v1_q)))
    else $error("load item changed first stage occupancy");

  // the delay-line pointer moves only on sample items
  a_wp_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !smp_acc |=> $stable(wp_q))
    else $error("write pointer moved without a sample item");
`endif

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the delay-and-sum beamformer. A short table of
// directed items runs first, then random sample, load and unknown-mode items
// over several back-pressure phases; every beam sample is checked in order
// against an in-bench model of the delay lines, fractional FIRs and averaging.
// ----------------------------------------------------------------------------
module tb;
  import dsb_pkg::*;

  localparam int     RAND_PER_PHASE = 250;
  localparam int     NUM_PHASES     = 5;
  localparam int     HOLD_CYCLES    = 300;
  localparam int     DRAIN_CYCLES   = 20;
  localparam int     DIR_ROWS       = 24;
  localparam longint SMP_MAX        = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SMP_MIN        = -(longint'(1) <<< (SAMPLE_BITS - 1));
  // the one mode code the block ignores
  localparam logic [MODE_FW-1:0] MODE_BAD = 2'd3;

  typedef struct packed {
    logic [MODE_FW-1:0]                 mode;
    logic [MICS-1:0][SAMPLE_BITS-1:0]   smp;
    logic [MIC_FW-1:0]                  mic;
    logic [TAP_FW-1:0]                  tap;
    logic [COEF_BITS-1:0]               coef;
    logic [DLY_FW-1:0]                  dly;
    logic                               en;
    logic                               has_want;
    logic [SAMPLE_BITS-1:0]             want;
  } stim_t;

  logic                   clk;
  logic                   rst_n;
  logic                   s_valid;
  logic                   s_ready;
  logic [IN_DATA_W-1:0]   s_data;
  logic [MODE_FW-1:0]     s_user;
  logic                   m_valid;
  logic                   m_ready;
  logic [OUT_DATA_W-1:0]  m_data;

  int          idle_pct;
  int          stall_pct;
  bit          hold_req;
  int          mismatch_count;
  sample_t     beam_expected[$];
  stim_t       dir_tab [DIR_ROWS];

  // bench copy of the beamformer state
  sample_t                     line_mem  [MICS][LINE_DEPTH];
  int                          wr_ptr;
  int                          chan_dly  [MICS];
  bit                          chan_fir  [MICS];
  logic signed [COEF_BITS-1:0] coef_mem  [MICS][TAPS];
  sample_t                     tap_hist  [MICS][TAPS-1];

  delay_and_sum_beamformer_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic longint clamp_sample(input longint v);
    if (v > SMP_MAX) begin
      return SMP_MAX;
    end else if (v < SMP_MIN) begin
      return SMP_MIN;
    end
    return v;
  endfunction

  function automatic void clear_state();
    wr_ptr = 0;
    for (int ch = 0; ch < MICS; ch++) begin
      chan_dly[ch] = 0;
      chan_fir[ch] = 1'b0;
      for (int k = 0; k < LINE_DEPTH; k++) line_mem[ch][k] = '0;
      for (int k = 0; k < TAPS; k++) coef_mem[ch][k] = '0;
      for (int k = 0; k < TAPS - 1; k++) tap_hist[ch][k] = '0;
    end
  endfunction

  // updates the bench state for one item, returns 1 when a beam sample results
  function automatic bit beam_predict(input stim_t it, output sample_t beam);
    longint sum;
    longint acc;
    longint x;
    longint num;
    longint q;
    int     rd;
    int     d;
    beam = '0;
    if (it.mode == MODE_COEF) begin
      if (it.mic < MICS && it.tap < TAPS) coef_mem[it.mic][it.tap] = it.coef;
      return 1'b0;
    end
    if (it.mode == MODE_CHAN) begin
      if (it.mic < MICS) begin
        d = int'(it.dly);
        if (d > LINE_DEPTH - 1) d = LINE_DEPTH - 1;
        chan_dly[it.mic] = d;
        chan_fir[it.mic] = it.en;
      end
      return 1'b0;
    end
    if (it.mode != MODE_SAMPLE) begin
      return 1'b0;
    end
    sum = 0;
    for (int ch = 0; ch < MICS; ch++) begin
      line_mem[ch][wr_ptr] = it.smp[ch];
      rd = (wr_ptr + LINE_DEPTH - chan_dly[ch]) % LINE_DEPTH;
      x = longint'(line_mem[ch][rd]);
      if (chan_fir[ch]) begin
        acc = longint'(coef_mem[ch][0]) * x;
        for (int k = 1; k < TAPS; k++) begin
          acc += longint'(coef_mem[ch][k]) * longint'(tap_hist[ch][k-1]);
        end
        acc += longint'(1) <<< (COEF_FRAC - 1);
        sum += clamp_sample(acc >>> COEF_FRAC);
      end else begin
        sum += x;
      end
      // history keeps running even with the filter switched off
      for (int k = TAPS - 2; k > 0; k--) tap_hist[ch][k] = tap_hist[ch][k-1];
      tap_hist[ch][0] = sample_t'(x);
    end
    wr_ptr = (wr_ptr + 1) % LINE_DEPTH;
    num = sum + MICS / 2;
    q = (num >= 0) ? num / MICS : -((-num + MICS - 1) / MICS);
    beam = sample_t'(clamp_sample(q));
    return 1'b1;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_item(input stim_t it);
    logic [IN_DATA_W-1:0] v;
    v = '0;
    for (int ch = 0; ch < MICS; ch++) v[ch*SAMPLE_BITS +: SAMPLE_BITS] = it.smp[ch];
    v[OFS_MIC +: MIC_FW]     = it.mic;
    v[OFS_TAP +: TAP_FW]     = it.tap;
    v[OFS_COEF +: COEF_BITS] = it.coef;
    v[OFS_DLY +: DLY_FW]     = it.dly;
    v[OFS_EN]                = it.en;
    return v;
  endfunction

  function automatic stim_t row(input int mode, input int s0, input int s1,
                                input int s2, input int s3, input int mic,
                                input int tap, input int coef, input int dly,
                                input int en, input bit has_want, input int want);
    stim_t r;
    r.mode     = mode[MODE_FW-1:0];
    r.smp[0]   = s0[SAMPLE_BITS-1:0];
    r.smp[1]   = s1[SAMPLE_BITS-1:0];
    r.smp[2]   = s2[SAMPLE_BITS-1:0];
    r.smp[3]   = s3[SAMPLE_BITS-1:0];
    r.mic      = mic[MIC_FW-1:0];
    r.tap      = tap[TAP_FW-1:0];
    r.coef     = coef[COEF_BITS-1:0];
    r.dly      = dly[DLY_FW-1:0];
    r.en       = en[0];
    r.has_want = has_want;
    r.want     = want[SAMPLE_BITS-1:0];
    return r;
  endfunction

  function automatic stim_t rand_item();
    stim_t r;
    int    pick;
    r = '0;
    pick = $urandom_range(99);
    if (pick < 70) begin
      r.mode = MODE_SAMPLE;
    end else if (pick < 85) begin
      r.mode = MODE_COEF;
    end else if (pick < 95) begin
      r.mode = MODE_CHAN;
    end else begin
      r.mode = MODE_BAD;
    end
    for (int ch = 0; ch < MICS; ch++) begin
      case ($urandom_range(7))
        0:       r.smp[ch] = SMP_MAX[SAMPLE_BITS-1:0];
        1:       r.smp[ch] = SMP_MIN[SAMPLE_BITS-1:0];
        2:       r.smp[ch] = '0;
        default: r.smp[ch] = SAMPLE_BITS'($urandom);
      endcase
    end
    r.mic = MIC_FW'($urandom_range(MICS - 1));
    // mostly taps in range, now and then any field value, ignored ones included
    r.tap = TAP_FW'(($urandom_range(7) == 0) ? $urandom_range(15)
                                             : $urandom_range(TAPS - 1));
    r.coef = ($urandom_range(1) == 0) ? COEF_BITS'($urandom)
                                      : COEF_BITS'(int'($urandom_range(8192)) - 4096);
    r.dly = DLY_FW'(($urandom_range(1) == 0) ? $urandom_range(7) : $urandom_range(63));
    r.en  = 1'($urandom_range(1));
    return r;
  endfunction

  task automatic send_item(input stim_t it);
    sample_t beam;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= pack_item(it);
    s_user  <= it.mode;
    do @(posedge clk); while (!s_ready);
    if (beam_predict(it, beam)) begin
      beam_expected.insert(beam_expected.size(), it.has_want ? sample_t'(it.want) : beam);
    end
  endtask

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    m_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    sample_t want;
    forever begin
      @(posedge clk);
      if (rst_n && m_valid && m_ready) begin
        if (beam_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected beam sample %0d",
                                    $signed(m_data[SAMPLE_BITS-1:0])));
        end else begin
          want = beam_expected.pop_front();
          if (m_data[SAMPLE_BITS-1:0] !== want) begin
            report_mismatch($sformatf("beam_sample got %0d want %0d",
                                      $signed(m_data[SAMPLE_BITS-1:0]), want));
          end
        end
      end
    end
  end

  initial begin
    int idle_of  [NUM_PHASES];
    int stall_of [NUM_PHASES];
    idle_of  = '{0, 69, 0, 29, 0};
    stall_of = '{0, 0, 69, 29, 0};
    rst_n          = 1'b0;
    s_valid        = 1'b0;
    s_data         = '0;
    s_user         = '0;
    idle_pct       = 0;
    stall_pct      = 0;
    hold_req       = 1'b0;
    mismatch_count = 0;
    clear_state();
    // rows with a typed value run straight after reset: zero delays, filters off
    dir_tab = '{
      row(MODE_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0),
      row(MODE_SAMPLE, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0, 1'b1, 32767),
      row(MODE_SAMPLE, -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0, 1'b1, -32768),
      row(MODE_SAMPLE, 32767, -32768, 32767, -32768, 0, 0, 0, 0, 0, 1'b1, 0),
      row(MODE_SAMPLE, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0),
      row(MODE_SAMPLE, 2, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1),
      row(MODE_SAMPLE, -3, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, -1),
      row(MODE_SAMPLE, -2, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0),
      // unknown mode with every other field set
      row(MODE_BAD, -1, -1, -1, -1, 3, 15, -1, 63, 1, 1'b0, 0),
      row(MODE_COEF, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 1'b0, 0),
      row(MODE_COEF, 0, 0, 0, 0, 0, 10, -32768, 0, 0, 1'b0, 0),
      // taps past the end are dropped
      row(MODE_COEF, 0, 0, 0, 0, 0, 11, 32767, 0, 0, 1'b0, 0),
      row(MODE_COEF, 0, 0, 0, 0, 0, 15, 32767, 0, 0, 1'b0, 0),
      row(MODE_COEF, 0, 0, 0, 0, 3, 5, 32767, 0, 0, 1'b0, 0),
      row(MODE_CHAN, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1'b0, 0),
      row(MODE_CHAN, 0, 0, 0, 0, 1, 0, 0, 63, 0, 1'b0, 0),
      row(MODE_CHAN, 0, 0, 0, 0, 3, 0, 0, 5, 1, 1'b0, 0),
      row(MODE_SAMPLE, 12345, -23456, 777, -9, 0, 0, 0, 0, 0, 1'b0, 0),
      row(MODE_SAMPLE, -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0, 1'b0, 0),
      row(MODE_COEF, 0, 0, 0, 0, 2, 0, -32768, 0, 0, 1'b0, 0),
      row(MODE_CHAN, 0, 0, 0, 0, 2, 0, 0, 1, 1, 1'b0, 0),
      // filter gain of minus two on a full-scale negative input saturates
      row(MODE_SAMPLE, -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0, 1'b0, 0),
      row(MODE_SAMPLE, -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0, 1'b0, 0),
      row(MODE_SAMPLE, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0, 1'b0, 0)
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i]) send_item(dir_tab[i]);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_pct  = idle_of[ph];
      stall_pct = stall_of[ph];
      // last phase: long output hold-off while the input keeps pushing
      if (ph == NUM_PHASES - 1) hold_req = 1'b1;
      repeat (RAND_PER_PHASE) send_item(rand_item());
    end
    s_valid <= 1'b0;
    while (beam_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && beam_expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/dsb_pkg.sv
rtl/core/dsb_lane.sv
rtl/core/dsb_merge.sv
rtl/core/delay_and_sum_beamformer_unit.sv
tb/sv/tb.sv
